// File: src/tsq_pkg.sv
// Package for the two-square pair cipher: payload structs, configuration
// types, register map codes and the cell-to-row/column tables.
// No dependencies.
package tsq_pkg;

    localparam int SYM_W      = 5;
    localparam int SIDE       = 5;
    localparam int CELLS      = SIDE * SIDE;
    localparam int PART_CELLS = 12;
    localparam int PART_W     = PART_CELLS * SYM_W;
    localparam int RC_W       = 3;
    localparam int IDX_W      = 5;
    localparam int APB_DW     = 64;
    localparam int APB_AW     = 6;
    localparam int REG_SEL_LO = 3;

    typedef logic [SYM_W-1:0] sym_t;
    typedef logic [CELLS-1:0][SYM_W-1:0] square_t;

    localparam sym_t PAD_RESET = 5'd23;

    typedef enum logic [2:0] {
        REG_SQ_A_P0  = 3'd0,
        REG_SQ_A_P1  = 3'd1,
        REG_SQ_A_P2  = 3'd2,
        REG_SQ_B_P0  = 3'd3,
        REG_SQ_B_P1  = 3'd4,
        REG_SQ_B_P2  = 3'd5,
        REG_DECRYPT  = 3'd6,
        REG_PAD      = 3'd7
    } reg_idx_t;

    typedef struct packed {
        sym_t first_symbol;
        sym_t second_symbol;
        logic second_present;
    } in_t;

    typedef struct packed {
        sym_t out_first;
        sym_t out_second;
        logic not_found;
    } out_t;

    typedef struct packed {
        square_t sq_a;
        square_t sq_b;
        logic    decrypt_mode;
        sym_t    pad_symbol;
    } cfg_t;

    typedef struct packed {
        logic            found;
        logic [RC_W-1:0] row;
        logic [RC_W-1:0] col;
    } loc_t;

    localparam logic [RC_W-1:0] CELL_ROW [CELLS] = '{
        3'd0, 3'd0, 3'd0, 3'd0, 3'd0,
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam logic [RC_W-1:0] CELL_COL [CELLS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd0, 3'd1, 3'd2, 3'd3, 3'd4
    };

endpackage

// File: src/tsq_cfg_regs.sv
// Configuration register file behind the APB-style port: both squares,
// the mode bit and the pad symbol.
// Depends on tsq_pkg.
module tsq_cfg_regs
    import tsq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t sel;
    logic     wr_en;

    assign sel    = reg_idx_t'(paddr[APB_AW-1:REG_SEL_LO]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (sel)
                REG_SQ_A_P0: begin
                    for (int k = 0; k < PART_CELLS; k++) begin
                        cfg_next.sq_a[k] = pwdata[k*SYM_W +: SYM_W];
                    end
                end
                REG_SQ_A_P1: begin
                    for (int k = 0; k < PART_CELLS; k++) begin
                        cfg_next.sq_a[PART_CELLS+k] = pwdata[k*SYM_W +: SYM_W];
                    end
                end
                REG_SQ_A_P2: cfg_next.sq_a[CELLS-1] = pwdata[SYM_W-1:0];
                REG_SQ_B_P0: begin
                    for (int k = 0; k < PART_CELLS; k++) begin
                        cfg_next.sq_b[k] = pwdata[k*SYM_W +: SYM_W];
                    end
                end
                REG_SQ_B_P1: begin
                    for (int k = 0; k < PART_CELLS; k++) begin
                        cfg_next.sq_b[PART_CELLS+k] = pwdata[k*SYM_W +: SYM_W];
                    end
                end
                REG_SQ_B_P2: cfg_next.sq_b[CELLS-1] = pwdata[SYM_W-1:0];
                REG_DECRYPT: cfg_next.decrypt_mode = pwdata[0];
                REG_PAD:     cfg_next.pad_symbol = pwdata[SYM_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (sel)
            REG_SQ_A_P0: begin
                for (int k = 0; k < PART_CELLS; k++) begin
                    prdata[k*SYM_W +: SYM_W] = cfg_reg.sq_a[k];
                end
            end
            REG_SQ_A_P1: begin
                for (int k = 0; k < PART_CELLS; k++) begin
                    prdata[k*SYM_W +: SYM_W] = cfg_reg.sq_a[PART_CELLS+k];
                end
            end
            REG_SQ_A_P2: prdata[SYM_W-1:0] = cfg_reg.sq_a[CELLS-1];
            REG_SQ_B_P0: begin
                for (int k = 0; k < PART_CELLS; k++) begin
                    prdata[k*SYM_W +: SYM_W] = cfg_reg.sq_b[k];
                end
            end
            REG_SQ_B_P1: begin
                for (int k = 0; k < PART_CELLS; k++) begin
                    prdata[k*SYM_W +: SYM_W] = cfg_reg.sq_b[PART_CELLS+k];
                end
            end
            REG_SQ_B_P2: prdata[SYM_W-1:0] = cfg_reg.sq_b[CELLS-1];
            REG_DECRYPT: prdata[0] = cfg_reg.decrypt_mode;
            REG_PAD:     prdata[SYM_W-1:0] = cfg_reg.pad_symbol;
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sq_a         <= '0;
            cfg_reg.sq_b         <= '0;
            cfg_reg.decrypt_mode <= 1'b0;
            cfg_reg.pad_symbol   <= PAD_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: src/tsq_locate.sv
// Parallel search of one 5x5 square for a symbol; the lowest matching
// cell wins and is reported as row and column.
// Depends on tsq_pkg.
module tsq_locate
    import tsq_pkg::*;
(
    input  square_t sq,
    input  sym_t    sym,
    output loc_t    loc
);

    // Scanning from the top cell down lets the lowest match overwrite.
    always_comb begin
        loc = '0;
        for (int i = CELLS - 1; i >= 0; i--) begin
            if (sq[i] == sym) begin
                loc.found = 1'b1;
                loc.row   = CELL_ROW[i];
                loc.col   = CELL_COL[i];
            end
        end
    end

endmodule

// File: src/tsq_pair_core.sv
// Combinational digraph transform: padding, square lookups and the
// two-square substitution rule for both modes.
// Depends on tsq_pkg and tsq_locate.
module tsq_pair_core
    import tsq_pkg::*;
(
    input  cfg_t cfg,
    input  in_t  item,
    output out_t res
);

    sym_t        s1;
    sym_t        s2;
    square_t     sq_f;
    square_t     sq_s;
    loc_t        loc_x;
    loc_t        loc_y;
    logic [IDX_W-1:0] idx1;
    logic [IDX_W-1:0] idx2;

    assign s1 = item.first_symbol;
    assign s2 = item.second_present ? item.second_symbol : cfg.pad_symbol;

    // The first symbol is searched in the first square (A when encrypting,
    // B when decrypting) and the second in the other one. In both modes the
    // first output then comes from the second square and vice versa.
    assign sq_f = cfg.decrypt_mode ? cfg.sq_b : cfg.sq_a;
    assign sq_s = cfg.decrypt_mode ? cfg.sq_a : cfg.sq_b;

    tsq_locate u_loc_x (
        .sq  (sq_f),
        .sym (s1),
        .loc (loc_x)
    );

    tsq_locate u_loc_y (
        .sq  (sq_s),
        .sym (s2),
        .loc (loc_y)
    );

    // Cell number is row * 5 + column, built as row * 4 + row + column.
    assign idx1 = {loc_x.row, 2'b00} + {2'b00, loc_x.row} + {2'b00, loc_y.col};
    assign idx2 = {loc_y.row, 2'b00} + {2'b00, loc_y.row} + {2'b00, loc_x.col};

    always_comb begin
        res = '0;
        if (!(loc_x.found && loc_y.found)) begin
            res.not_found = 1'b1;
        end else if (loc_x.row != loc_y.row) begin
            res.out_first  = sq_s[idx1];
            res.out_second = sq_f[idx2];
        end else begin
            res.out_first  = s2;
            res.out_second = s1;
        end
    end

endmodule

// File: src/two_square_pair_cipher.sv
// Two-square digraph cipher: top level with the input and result registers.
// Depends on tsq_pkg, tsq_cfg_regs and tsq_pair_core.
//
// Usage:
//   Input channel s_valid/s_ready/s_data carries one symbol pair per word;
//   when second_present is low the configured pad symbol replaces the
//   second symbol. Result channel m_valid/m_ready/m_data returns one
//   transformed pair per input word, in order, with not_found set (and both
//   symbols zero) when a symbol is missing from its square.
//   Squares, mode and pad symbol are loaded through the APB-style port while
//   the block is idle; each register sits at byte address 8 * index.
// Timing:
//   An accepted word first sits in the input register, then the square
//   search and substitution land in the result register. Throughput is one
//   word per cycle while the receiver takes results, set by the
//   combinational parallel search over both squares.
// Reset and stall:
//   aresetn (synchronous, active low) empties both registers and loads the
//   default configuration (zero squares, encrypt, pad symbol 23). When the
//   receiver stalls, one word waits in each register before s_ready drops.
module two_square_pair_cipher
    import tsq_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_t               s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_t              m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    cfg_t cfg;
    logic in_vld_reg;
    logic in_vld_next;
    in_t  in_data_reg;
    logic out_vld_reg;
    logic out_vld_next;
    out_t out_data_reg;
    out_t core_res;
    logic out_adv;

    tsq_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tsq_pair_core u_core (
        .cfg  (cfg),
        .item (in_data_reg),
        .res  (core_res)
    );

    assign out_adv = !out_vld_reg || m_ready;
    assign s_ready = !in_vld_reg || out_adv;
    assign m_valid = out_vld_reg;
    assign m_data  = out_data_reg;

    always_comb begin
        in_vld_next  = s_ready ? s_valid : in_vld_reg;
        out_vld_next = out_adv ? in_vld_reg : out_vld_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (out_adv && in_vld_reg) begin
            out_data_reg <= core_res;
        end
    end

`ifndef SYNTHESIS
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.not_found |-> m_data.out_first == '0 && m_data.out_second == '0)
        else $error("not_found result carries nonzero symbols");

    a_rise_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_vld_reg))
        else $error("result appeared without a word in the input register");

    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !m_valid |=> m_valid)
        else $error("input word did not move into an empty result register");
`endif

endmodule
